// ===== rtl/lscp_pkg.sv =====
// lscp_pkg: shared types, codes and helpers for the line sensor calibrate/position block
`timescale 1ns / 1ps
`default_nettype none

package lscp_pkg;

    // adc full scale and fixed widths
    localparam int SAMPLE_W = 12;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'd4095;

    // saturating sweep counters
    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // centroid scale factor
    localparam int CENTROID_SCALE = 1000;

    // divider geometry
    localparam int DIVIDEND_W = 34;
    localparam int DIVISOR_W  = 16;
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'(DIVIDEND_W - 1);

    // reciprocal of three over 2^13
    localparam logic [25:0] RECIP3 = 26'd2731;

    // configuration register indexes
    localparam logic [1:0] REG_INVERT_LINE  = 2'd0;
    localparam logic [1:0] REG_MIN_SPAN     = 2'd1;
    localparam logic [1:0] REG_OUTPUT_LIMIT = 2'd2;

    // register reset values
    localparam logic [11:0] MIN_SPAN_RST     = 12'd1000;
    localparam logic [14:0] OUTPUT_LIMIT_RST = 15'd1000;

    // operation and result kind codes
    localparam logic OP_CALIBRATE = 1'b0;
    localparam logic OP_MEASURE   = 1'b1;

    // per-sensor calibration entry
    typedef struct packed {
        logic [SAMPLE_W-1:0] peak;
        logic [SAMPLE_W-1:0] floor_lvl;
        logic [SAMPLE_W-1:0] thr;
    } lscp_entry_t;

    localparam lscp_entry_t ENTRY_RST = '{peak: '0, floor_lvl: FULL_SCALE, thr: '0};

    // position sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEAN,
        ST_MUL,
        ST_SCALE,
        ST_DONE
    } lscp_state_t;

    // floor(span * 2 / 3) by reciprocal multiply and one correction
    function automatic logic [SAMPLE_W-1:0] two_thirds(input logic [SAMPLE_W-1:0] span);
        logic [12:0] y;
        logic [25:0] prod;
        logic [12:0] q;
        logic [14:0] r;
        y    = {span, 1'b0};
        prod = 26'(y) * RECIP3;
        q    = prod[25:13];
        r    = 15'(y) - 15'(q) * 15'd3;
        if (r[14])
        begin
            q = q - 13'd1;
        end
        else if (r >= 15'd3)
        begin
            q = q + 13'd1;
        end
        return q[SAMPLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/line_sensor_calibrate_and_position_top.sv =====
// line_sensor_calibrate_and_position_top: sensor calibration memory and centroid position
//
// channel   signals                                  direction
// in        in_valid / in_stall + sample fields      upstream -> block
// out       out_valid / out_stall + result fields    block -> downstream
// cfg       cfg_valid / cfg_ready, cfg_index/data    host -> block
//
// a sample that does not end a sweep reads its sensor entry at accept, then is
// modified and written back in the next cycle, with forwarding for back to back samples
// a sweep end item with a calibration or line-lost result stalls input until it is loaded
// a position result runs 34 steps of the one-bit-per-cycle mean divider, then
// a limit multiply, a reciprocal scaling and the output load; no item is taken meanwhile
// a stalled output delays the result load; reset clears the entry valid bits at once
`timescale 1ns / 1ps
`default_nettype none

module line_sensor_calibrate_and_position_top #(
    parameter int SENSOR_COUNT = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // sample channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [3:0]  sensor_index,
    input  wire logic [11:0] sample,
    input  wire logic        sweep_end,
    input  wire logic signed [15:0] previous_position,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic signed [15:0] position,
    output logic             line_found,
    output logic             all_calibrated,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);

    import lscp_pkg::*;

    // sensor count is limited to 2..16 by the four-bit index
    localparam int IDX_W = $clog2(SENSOR_COUNT);
    localparam logic [4:0] SENSOR_LIM = 5'(SENSOR_COUNT);
    localparam logic [CNT_W-1:0] SENSOR_CNT = CNT_W'(SENSOR_COUNT);

    // scaled position is floor(mean * L / (500 * (N + 1))); the product over four
    // stays below 2^31, so a rounded-up reciprocal of 125 * (N + 1) is exact
    localparam int SCALE_DIV_Q = CENTROID_SCALE * (SENSOR_COUNT + 1) / 8;
    localparam int SCALE_SHIFT = 31 + $clog2(SCALE_DIV_Q);
    localparam logic [31:0] SCALE_RECIP =
        32'(((64'd1 << SCALE_SHIFT) + 64'(SCALE_DIV_Q - 1)) / 64'(SCALE_DIV_Q));

    // configuration registers
    logic        invert_line_reg;
    logic [11:0] min_span_reg;
    logic [14:0] output_limit_reg;

    // entry memory and its valid bits
    lscp_entry_t mem [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] entry_valid_reg;
    lscp_entry_t rd_data_reg;
    logic        rd_valid_reg;
    logic        rd_fwd_reg;
    lscp_entry_t fwd_data_reg;

    // modify stage
    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [IDX_W-1:0]    s1_addr_reg;
    logic                s1_ok_reg;
    logic [SAMPLE_W-1:0] s1_smp_reg;
    logic                s1_end_reg;
    logic                s1_prev_neg_reg;

    // sweep counters
    logic [CNT_W-1:0] det_cnt_reg, det_cnt_next, det_upd;
    logic [CNT_W-1:0] idx_sum_reg, idx_sum_next, sum_upd;
    logic [CNT_W-1:0] span_cnt_reg, span_cnt_next, span_upd;

    // position sequencer and divider
    lscp_state_t            state_reg, state_next;
    logic [DIVIDEND_W-1:0]  quo_reg;
    logic [DIVISOR_W-1:0]   rem_reg;
    logic [DIVISOR_W-1:0]   divisor_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic                   div_step;
    logic                   div_load_mul;
    logic                   div_scale;
    logic                   out_load_div;
    logic [62:0]            scale_prod;

    // output register
    logic             out_valid_reg;
    logic             kind_reg;
    logic [15:0]      position_reg;
    logic             line_found_reg;
    logic             all_cal_reg;

    // combinational signals
    logic                in_fire;
    logic                out_free;
    logic                idx_ok;
    logic [IDX_W-1:0]    rd_addr;
    logic [SAMPLE_W-1:0] smp_clamp;
    logic [SAMPLE_W-1:0] smp_proc;
    lscp_entry_t         cur_entry;
    lscp_entry_t         wr_entry;
    logic [SAMPLE_W-1:0] span;
    logic                mem_we;
    logic                det_hit;
    logic                span_hit;
    logic                found_now;
    logic                div_start;
    logic                s1_fire;
    logic                out_load_direct;
    logic [15:0]         lim_pos;
    logic [15:0]         lim_neg;
    logic [15:0]         pos_div;
    logic [DIVISOR_W:0]  trial;
    logic                trial_ge;

    // handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || (s1_valid_reg && s1_end_reg);
    assign in_fire   = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_line_reg  <= 1'b0;
            min_span_reg     <= MIN_SPAN_RST;
            output_limit_reg <= OUTPUT_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_INVERT_LINE:  invert_line_reg  <= cfg_data[0];
                REG_MIN_SPAN:     min_span_reg     <= cfg_data[11:0];
                REG_OUTPUT_LIMIT: output_limit_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // sample clamp and inversion
    assign smp_clamp = (sample > FULL_SCALE) ? FULL_SCALE : sample;
    assign smp_proc  = invert_line_reg ? (FULL_SCALE - smp_clamp) : smp_clamp;
    assign idx_ok    = {1'b0, sensor_index} < SENSOR_LIM;
    assign rd_addr   = sensor_index[IDX_W-1:0];

    // entry memory: write from modify stage, registered read at accept
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[s1_addr_reg] <= wr_entry;
        end
        if (in_fire)
        begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_entry;
        end
    end

    // valid bits and forwarding flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            rd_fwd_reg      <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                entry_valid_reg[s1_addr_reg] <= 1'b1;
            end
            if (in_fire)
            begin
                rd_valid_reg <= entry_valid_reg[rd_addr];
                rd_fwd_reg   <= mem_we && (s1_addr_reg == rd_addr);
            end
        end
    end

    // modify stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg       <= op;
            s1_addr_reg     <= rd_addr;
            s1_ok_reg       <= idx_ok;
            s1_smp_reg      <= smp_proc;
            s1_end_reg      <= sweep_end;
            s1_prev_neg_reg <= previous_position[15];
        end
    end

    // current entry with forwarding and reset value for unwritten entries
    always_comb
    begin
        if (rd_fwd_reg)
        begin
            cur_entry = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            cur_entry = rd_data_reg;
        end
        else
        begin
            cur_entry = ENTRY_RST;
        end
    end

    // calibration update of the entry
    always_comb
    begin
        wr_entry.peak      = (s1_smp_reg > cur_entry.peak) ? s1_smp_reg : cur_entry.peak;
        wr_entry.floor_lvl = (s1_smp_reg < cur_entry.floor_lvl) ? s1_smp_reg
                                                                 : cur_entry.floor_lvl;
        span               = wr_entry.peak - wr_entry.floor_lvl;
        wr_entry.thr       = wr_entry.floor_lvl + two_thirds(span);
    end

    assign mem_we   = s1_fire && s1_ok_reg && (s1_op_reg == OP_CALIBRATE);
    assign span_hit = s1_valid_reg && s1_ok_reg && (s1_op_reg == OP_CALIBRATE)
                      && (span >= min_span_reg);
    assign det_hit  = s1_valid_reg && s1_ok_reg && (s1_op_reg == OP_MEASURE)
                      && (s1_smp_reg >= cur_entry.thr);

    // saturating counter updates including the current item
    always_comb
    begin
        logic [CNT_W:0] d_sum;
        logic [CNT_W:0] i_sum;
        logic [CNT_W:0] s_sum;
        d_sum    = {1'b0, det_cnt_reg} + (CNT_W+1)'(det_hit);
        i_sum    = {1'b0, idx_sum_reg}
                   + (det_hit ? ((CNT_W+1)'(s1_addr_reg) + (CNT_W+1)'(1)) : '0);
        s_sum    = {1'b0, span_cnt_reg} + (CNT_W+1)'(span_hit);
        det_upd  = (d_sum > {1'b0, CNT_MAX}) ? CNT_MAX : d_sum[CNT_W-1:0];
        sum_upd  = (i_sum > {1'b0, CNT_MAX}) ? CNT_MAX : i_sum[CNT_W-1:0];
        span_upd = (s_sum > {1'b0, CNT_MAX}) ? CNT_MAX : s_sum[CNT_W-1:0];
    end

    // sweep end decisions
    assign found_now = (det_upd != '0) && (det_upd < SENSOR_CNT);
    assign div_start = s1_valid_reg && s1_end_reg && (s1_op_reg == OP_MEASURE) && found_now;
    assign s1_fire   = s1_valid_reg && (!s1_end_reg || div_start || out_free);
    assign out_load_direct = s1_fire && s1_end_reg && !div_start;

    // counter next values
    always_comb
    begin
        det_cnt_next  = det_cnt_reg;
        idx_sum_next  = idx_sum_reg;
        span_cnt_next = span_cnt_reg;
        if (s1_fire)
        begin
            det_cnt_next  = s1_end_reg ? '0 : det_upd;
            idx_sum_next  = s1_end_reg ? '0 : sum_upd;
            span_cnt_next = s1_end_reg ? '0 : span_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            det_cnt_reg  <= '0;
            idx_sum_reg  <= '0;
            span_cnt_reg <= '0;
        end
        else
        begin
            det_cnt_reg  <= det_cnt_next;
            idx_sum_reg  <= idx_sum_next;
            span_cnt_reg <= span_cnt_next;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (div_start)
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_step     = 1'b0;
        div_load_mul = 1'b0;
        div_scale    = 1'b0;
        out_load_div = 1'b0;
        unique case (state_reg)
            ST_IDLE:  ;
            ST_MEAN:  div_step = 1'b1;
            ST_MUL:   div_load_mul = 1'b1;
            ST_SCALE: div_scale = 1'b1;
            ST_DONE:  out_load_div = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // restoring divider step
    assign trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign trial_ge = trial >= {1'b0, divisor_reg};

    // reciprocal scaling of mean times limit, taken over four
    assign scale_prod = 63'(quo_reg[32:2]) * 63'(SCALE_RECIP);

    // divider datapath: mean index pass, limit multiply, reciprocal scaling
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            quo_reg     <= DIVIDEND_W'(sum_upd) * DIVIDEND_W'(CENTROID_SCALE);
            divisor_reg <= DIVISOR_W'(det_upd);
            rem_reg     <= '0;
            cnt_reg     <= '0;
        end
        else if (div_step)
        begin
            rem_reg <= trial_ge ? DIVISOR_W'(trial - {1'b0, divisor_reg})
                                : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], trial_ge};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
        else if (div_load_mul)
        begin
            quo_reg <= DIVIDEND_W'(quo_reg[17:0]) * DIVIDEND_W'(output_limit_reg);
        end
        else if (div_scale)
        begin
            quo_reg <= DIVIDEND_W'(scale_prod >> SCALE_SHIFT);
        end
    end

    // position limits and scaled position with clamp
    assign lim_pos = {1'b0, output_limit_reg};
    assign lim_neg = 16'(~lim_pos + 16'd1);
    assign pos_div = (quo_reg > DIVIDEND_W'({output_limit_reg, 1'b0})) ? lim_pos
                     : (quo_reg[15:0] - lim_pos);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_direct || out_load_div)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load_direct)
        begin
            kind_reg       <= s1_op_reg;
            line_found_reg <= 1'b0;
            if (s1_op_reg == OP_CALIBRATE)
            begin
                position_reg <= '0;
                all_cal_reg  <= span_upd >= SENSOR_CNT;
            end
            else
            begin
                position_reg <= s1_prev_neg_reg ? lim_neg : lim_pos;
                all_cal_reg  <= 1'b0;
            end
        end
        else if (out_load_div)
        begin
            kind_reg       <= OP_MEASURE;
            position_reg   <= pos_div;
            line_found_reg <= 1'b1;
            all_cal_reg    <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kind           = kind_reg;
    assign position       = $signed(position_reg);
    assign line_found     = line_found_reg;
    assign all_calibrated = all_cal_reg;

    // modify stage is empty while the sequencer works
    a_s1_empty_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_valid_reg && (state_reg != ST_IDLE)))
        else $error("sample in modify stage while position sequencer busy");

    // written threshold lies between floor and peak
    a_thr_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (wr_entry.floor_lvl <= wr_entry.thr) && (wr_entry.thr <= wr_entry.peak))
        else $error("threshold outside calibrated span");

    // position results stay within the output limit
    a_pos_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg && line_found_reg) |->
            ($signed({position_reg[15], position_reg}) <= $signed({1'b0, lim_pos}))
            && ($signed({position_reg[15], position_reg}) >= -$signed({1'b0, lim_pos})))
        else $error("position result beyond output limit");

    // a divider pass never runs past its last step
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_MEAN) && (cnt_reg == DIV_LAST)) |=> (state_reg == ST_MUL))
        else $error("mean pass did not hand over to scaling");

endmodule

`default_nettype wire
